/* rtl/lcdr_pkg.sv */
// ----------------------------------------------------------------------------
// lcdr_pkg
// Shared types, constants and glyph tables for the segment LCD renderer.
// ----------------------------------------------------------------------------
package lcdr_pkg;

    localparam int NUM_ADDRESSES_DEF = 32;
    localparam int NUM_DIGITS        = 4;
    localparam int NUM_SEGS          = 7;

    localparam logic [13:0] MAX_VALUE   = 14'd9999;
    localparam logic [13:0] DEC_BASE    = 14'd10;
    // floor(x / 10) == (x * 52429) >> 19 for every x below 2^16
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [2:0]  WRITE_ID    = 3'b101;

    typedef struct packed {
        logic       valid;
        logic [4:0] addr;
        logic [1:0] com;
    } seg_place_t;

    localparam seg_place_t NO_SEG     = '{1'b0, 5'd0, 2'd0};
    localparam seg_place_t COLON_SEG  = '{1'b1, 5'd8, 2'd3};
    localparam seg_place_t PM_SEG     = '{1'b1, 5'd3, 2'd3};

    // digit (0 = rightmost) by segment a..g
    localparam seg_place_t SEG_PLACE [NUM_DIGITS][NUM_SEGS] = '{
        '{'{1'b1, 5'd10, 2'd3}, '{1'b1, 5'd10, 2'd2}, '{1'b1, 5'd10, 2'd1},
          '{1'b1, 5'd9, 2'd1},  '{1'b1, 5'd8, 2'd1},  '{1'b1, 5'd9, 2'd3},
          '{1'b1, 5'd9, 2'd2}},
        '{'{1'b1, 5'd8, 2'd2},  '{1'b1, 5'd7, 2'd3},  '{1'b1, 5'd7, 2'd1},
          '{1'b1, 5'd6, 2'd1},  '{1'b1, 5'd6, 2'd2},  '{1'b1, 5'd6, 2'd3},
          '{1'b1, 5'd7, 2'd2}},
        '{'{1'b1, 5'd4, 2'd3},  '{1'b1, 5'd5, 2'd2},  '{1'b1, 5'd5, 2'd1},
          '{1'b1, 5'd4, 2'd1},  '{1'b1, 5'd3, 2'd1},  '{1'b1, 5'd3, 2'd2},
          '{1'b1, 5'd4, 2'd2}},
        '{NO_SEG,               '{1'b1, 5'd2, 2'd2},  '{1'b1, 5'd2, 2'd1},
          NO_SEG,               NO_SEG,               NO_SEG,
          '{1'b1, 5'd1, 2'd2}}
    };

    // one rendered display: lit segments per digit plus the indicators
    typedef struct packed {
        logic [NUM_DIGITS-1:0][NUM_SEGS-1:0] lit;
        logic                                colon;
        logic                                pm;
    } lcdr_item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SPLIT,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic busy;
        logic load;
        logic split;
        logic push;
    } front_ctl_t;

    function automatic logic [NUM_SEGS-1:0] glyph(input logic [3:0] digit);
        logic [NUM_SEGS-1:0] g;
        unique case (digit)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

endpackage

/* rtl/lcdr_front.sv */
// ----------------------------------------------------------------------------
// lcdr_front
// Takes a command, clamps the value, splits it into decimal digits one per
// cycle, blanks leading zeros and pushes the lit segment set to the queue.
// ----------------------------------------------------------------------------
module lcdr_front
    import lcdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] value,
    input  logic        show_colon,
    input  logic        pm_on,
    output logic        busy,
    input  logic        q_full,
    output logic        q_push,
    output lcdr_item_t  q_item
);

    front_state_t state_reg, state_next;
    front_ctl_t   ctl;

    logic [13:0] rest_reg;
    logic [1:0]  cnt_reg;
    logic [3:0]  digit_reg [NUM_DIGITS];
    logic        colon_reg;
    logic        pm_reg;

    logic [29:0] prod;
    logic [13:0] quot;
    logic [13:0] diff;
    logic [13:0] sat_value;
    logic [NUM_DIGITS-1:0] shown;

    assign sat_value = (value > {2'b00, MAX_VALUE}) ? MAX_VALUE : value[13:0];
    assign prod      = 30'(rest_reg) * 30'(DIV10_MUL);
    assign quot      = 14'(prod >> DIV10_SHIFT);
    assign diff      = rest_reg - 14'(quot * DEC_BASE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (start) state_next = F_SPLIT;
            F_SPLIT: if (cnt_reg == 2'(NUM_DIGITS - 1)) state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                ctl.load = start;
            end
            F_SPLIT:
            begin
                ctl.busy  = 1'b1;
                ctl.split = 1'b1;
            end
            F_PUSH:
            begin
                ctl.busy = 1'b1;
                ctl.push = !q_full;
            end
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load)
                cnt_reg <= '0;
            else if (ctl.split)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rest_reg  <= sat_value;
            colon_reg <= show_colon;
            pm_reg    <= pm_on;
        end
        else if (ctl.split)
        begin
            rest_reg           <= quot;
            digit_reg[cnt_reg] <= diff[3:0];
        end
    end

    // rightmost always shows; others if they or a higher digit are nonzero
    assign shown[0] = 1'b1;
    assign shown[3] = digit_reg[3] != 4'd0;
    assign shown[2] = shown[3] || digit_reg[2] != 4'd0;
    assign shown[1] = shown[2] || digit_reg[1] != 4'd0;

    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            q_item.lit[d] = shown[d] ? glyph(digit_reg[d]) : '0;
        end
        q_item.colon = colon_reg;
        q_item.pm    = pm_reg;
    end

    assign busy   = ctl.busy;
    assign q_push = ctl.push;

endmodule

/* rtl/lcdr_queue.sv */
// ----------------------------------------------------------------------------
// lcdr_queue
// Two-entry FIFO of rendered displays between front and back.
// ----------------------------------------------------------------------------
module lcdr_queue
    import lcdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lcdr_item_t push_item,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output lcdr_item_t head_item
);

    lcdr_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_item = entry_reg[rd_ptr_reg];

endmodule

/* rtl/lcdr_back.sv */
// ----------------------------------------------------------------------------
// lcdr_back
// Walks the display RAM addresses for one rendered display and emits one
// registered nibble write per address.
// ----------------------------------------------------------------------------
module lcdr_back
    import lcdr_pkg::*;
#(
    parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  lcdr_item_t  q_item,
    output logic        q_pop,
    output logic        strobe,
    output logic [4:0]  ram_address,
    output logic [3:0]  ram_nibble,
    output logic [12:0] serial_frame,
    output logic        last_write
);

    localparam int AW = $clog2(NUM_ADDRESSES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ADDRESSES - 1);

    logic          active_reg;
    logic [AW-1:0] cnt_reg;
    lcdr_item_t    item_reg;

    logic        strobe_reg;
    logic [4:0]  address_reg;
    logic [3:0]  nibble_reg;
    logic [12:0] frame_reg;
    logic        last_reg;

    logic [5:0] addr6;
    logic [3:0] nib;
    logic       at_last;
    logic       load;

    assign addr6   = 6'(cnt_reg);
    assign at_last = cnt_reg == LAST_ADDR;
    assign load    = q_not_empty && (!active_reg || at_last);
    assign q_pop   = load;

    // OR in every lit segment that maps to the current address
    always_comb
    begin
        nib = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            for (int s = 0; s < NUM_SEGS; s++)
            begin
                if (item_reg.lit[d][s] && SEG_PLACE[d][s].valid
                    && {1'b0, SEG_PLACE[d][s].addr} == addr6)
                    nib[SEG_PLACE[d][s].com] = 1'b1;
            end
        end
        if (item_reg.colon && {1'b0, COLON_SEG.addr} == addr6)
            nib[COLON_SEG.com] = 1'b1;
        if (item_reg.pm && {1'b0, PM_SEG.addr} == addr6)
            nib[PM_SEG.com] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                if (at_last)
                    active_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= q_item;
        if (active_reg)
        begin
            address_reg <= addr6[4:0];
            nibble_reg  <= nib;
            frame_reg   <= {WRITE_ID, addr6, nib};
            last_reg    <= at_last;
        end
    end

    assign strobe       = strobe_reg;
    assign ram_address  = address_reg;
    assign ram_nibble   = nibble_reg;
    assign serial_frame = frame_reg;
    assign last_write   = last_reg;

endmodule

/* rtl/four_digit_segment_lcd_renderer_core.sv */
// ----------------------------------------------------------------------------
// four_digit_segment_lcd_renderer_core
// Renders a clamped 4-digit number with colon and PM flags into a run of
// display RAM nibble writes, one per address.
// ----------------------------------------------------------------------------
//  channel   handshake       payload
//  command   start / busy    value, show_colon, pm_on
//  writes    strobe          ram_address, ram_nibble, serial_frame, last_write
//
//  Each command yields NUM_ADDRESSES writes with no gap between them; the
//  command is held in the back end's item register and each write is
//  registered at the outputs. The back end pops the next command while it
//  emits the last address, so writes of queued commands run on unbroken.
//  The front end accepts a command, splits off its decimal digits in turn
//  and pushes the result; a two-entry queue lets it run ahead of the writes.
//  busy is high while the front end works or waits on a full queue.
//  Writes cannot be stalled. Reset clears all control state at once.
// ----------------------------------------------------------------------------
module four_digit_segment_lcd_renderer_core
    import lcdr_pkg::*;
#(
    parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] value,
    input  logic        show_colon,
    input  logic        pm_on,
    output logic        strobe,
    output logic [4:0]  ram_address,
    output logic [3:0]  ram_nibble,
    output logic [12:0] serial_frame,
    output logic        last_write
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    lcdr_item_t push_item;
    lcdr_item_t head_item;

    lcdr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .show_colon (show_colon),
        .pm_on      (pm_on),
        .busy       (busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    lcdr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    lcdr_back #(
        .NUM_ADDRESSES (NUM_ADDRESSES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .strobe       (strobe),
        .ram_address  (ram_address),
        .ram_nibble   (ram_nibble),
        .serial_frame (serial_frame),
        .last_write   (last_write)
    );

endmodule
